// ----- src/circle_internal_tangents_assert.svh -----
// Assertion macros used by the checker file.
`ifndef CIRCLE_INTERNAL_TANGENTS_ASSERT_SVH
`define CIRCLE_INTERNAL_TANGENTS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CIT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle_internal_tangents check failed");

// Next-cycle implication, checked out of reset.
`define CIT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle_internal_tangents check failed");

`endif

// ----- src/citp_pkg.sv -----
// Shared widths, types and helper functions for the internal tangent pipeline.
`timescale 1ns / 1ps
package citp_pkg;

    localparam int CW        = 24;            // coordinate width
    localparam int RW        = 23;            // radius width
    localparam int DW        = 25;            // center difference, signed
    localparam int VW        = 25;            // magnitude of a difference
    localparam int RRW       = 24;            // r1 + r2
    localparam int D2W       = 50;            // squared distance
    localparam int FRAC      = 7;             // fraction bits of the root
    localparam int SQW       = D2W + 2 * FRAC;
    localparam int TW        = SQW / 2;       // root width
    localparam int REMW      = TW + 4;
    localparam int KW        = 57;            // coefficient width
    localparam int KLW       = 29;
    localparam int KHW       = KW - KLW;
    localparam int PW        = 82;            // coefficient times magnitude
    localparam int NW        = 84;            // rounded numerator
    localparam int DENW      = D2W + FRAC;
    localparam int QW        = 27;            // quotient magnitude
    localparam int SW        = QW + 2;        // signed quotient plus base
    localparam int SQ_STAGES = TW;
    localparam int DIV_STAGES = QW;
    localparam int COMPS     = 4;
    localparam int LANES     = 2 * COMPS;
    localparam int PRODS     = 8;
    localparam int PIW       = 3;
    localparam int COMP_W    = 2;
    localparam int IN_TW     = 144;
    localparam int OUT_TW    = LANES * CW;
    localparam int OUT_MAX   = 2 ** (CW - 1) - 1;
    localparam int OUT_MIN   = -(2 ** (CW - 1));

    // component codes inside one line
    localparam logic [COMP_W-1:0] COMP_SX = 2'd0;
    localparam logic [COMP_W-1:0] COMP_SY = 2'd1;
    localparam logic [COMP_W-1:0] COMP_VX = 2'd2;
    localparam logic [COMP_W-1:0] COMP_VY = 2'd3;

    // product codes: coefficient times |dx| or |dy|
    localparam logic [PIW-1:0] P_SD_X = 3'd0;
    localparam logic [PIW-1:0] P_SD_Y = 3'd1;
    localparam logic [PIW-1:0] P_SQ_Y = 3'd2;
    localparam logic [PIW-1:0] P_SQ_X = 3'd3;
    localparam logic [PIW-1:0] P_DD_X = 3'd4;
    localparam logic [PIW-1:0] P_DD_Y = 3'd5;
    localparam logic [PIW-1:0] P_DQ_Y = 3'd6;
    localparam logic [PIW-1:0] P_DQ_X = 3'd7;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t                  x1;
        coord_t                  y1;
        logic [RW-1:0]           r1;
        logic [RRW-1:0]          rr;
        logic [RW+RRW-1:0]       r1rr;
        logic signed [DW-1:0]    dx;
        logic signed [DW-1:0]    dy;
        logic [D2W-1:0]          d2;
        logic [D2W-1:0]          diff;
        logic                    ok;
    } geo_t;

    typedef struct packed {
        coord_t                  x1;
        coord_t                  y1;
        logic                    dxn;
        logic                    dyn;
        logic                    qyn;
        logic                    ok;
        logic [DENW-1:0]         den;
    } tside_t;

    typedef struct packed {
        coord_t                  x1;
        coord_t                  y1;
        logic [LANES-1:0]        neg;
        logic                    ok;
    } dside_t;

    typedef struct packed {
        logic [REMW-1:0]         rem;
        logic [TW-1:0]           root;
    } sq_t;

    // one digit of the restoring square root
    function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
        logic [REMW-1:0] acc;
        logic [REMW-1:0] trial;
        sq_t             res;
        acc   = {cur.rem[REMW-3:0], pair};
        trial = {{(REMW-TW-2){1'b0}}, cur.root, 2'b01};
        if (acc >= trial)
        begin
            res.rem  = acc - trial;
            res.root = {cur.root[TW-2:0], 1'b1};
        end
        else
        begin
            res.rem  = acc;
            res.root = {cur.root[TW-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ----- src/citp_front.sv -----
// Front stages: center differences, squares, distance test.
`timescale 1ns / 1ps
module citp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  citp_pkg::coord_t           x1,
    input  citp_pkg::coord_t           y1,
    input  logic [citp_pkg::RW-1:0]    r1,
    input  citp_pkg::coord_t           x2,
    input  citp_pkg::coord_t           y2,
    input  logic [citp_pkg::RW-1:0]    r2,
    output logic                       out_valid,
    output citp_pkg::geo_t             geo,
    output logic [citp_pkg::SQW-1:0]   sq_in
);
    import citp_pkg::*;

    logic                   v1_reg, v2_reg, v3_reg;
    coord_t                 x1_1_reg, y1_1_reg, x1_2_reg, y1_2_reg;
    logic [RW-1:0]          r1_1_reg, r1_2_reg;
    logic signed [DW-1:0]   dx_1_reg, dy_1_reg, dx_2_reg, dy_2_reg;
    logic [RRW-1:0]         rr_1_reg, rr_2_reg;
    logic [D2W-1:0]         sqx_reg, sqy_reg, rrsq_reg;
    logic [RW+RRW-1:0]      r1rr_reg;
    geo_t                   geo_reg;
    logic [SQW-1:0]         sq_reg;

    logic [VW-1:0]          adx, ady;
    logic [D2W-1:0]         d2_next, diff_next;
    logic                   ok_next;

    always_comb
    begin
        adx       = dx_1_reg[DW-1] ? VW'(-dx_1_reg) : VW'(dx_1_reg);
        ady       = dy_1_reg[DW-1] ? VW'(-dy_1_reg) : VW'(dy_1_reg);
        d2_next   = sqx_reg + sqy_reg;
        ok_next   = (d2_next != '0) && (d2_next >= rrsq_reg);
        diff_next = d2_next - rrsq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_1_reg <= x1;
            y1_1_reg <= y1;
            r1_1_reg <= r1;
            dx_1_reg <= {x2[CW-1], x2} - {x1[CW-1], x1};
            dy_1_reg <= {y2[CW-1], y2} - {y1[CW-1], y1};
            rr_1_reg <= {1'b0, r1} + {1'b0, r2};

            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            r1_2_reg <= r1_1_reg;
            dx_2_reg <= dx_1_reg;
            dy_2_reg <= dy_1_reg;
            rr_2_reg <= rr_1_reg;
            sqx_reg  <= D2W'(adx) * D2W'(adx);
            sqy_reg  <= D2W'(ady) * D2W'(ady);
            rrsq_reg <= D2W'(rr_1_reg) * D2W'(rr_1_reg);
            r1rr_reg <= (RW+RRW)'(r1_1_reg) * (RW+RRW)'(rr_1_reg);

            geo_reg.x1   <= x1_2_reg;
            geo_reg.y1   <= y1_2_reg;
            geo_reg.r1   <= r1_2_reg;
            geo_reg.rr   <= rr_2_reg;
            geo_reg.r1rr <= r1rr_reg;
            geo_reg.dx   <= dx_2_reg;
            geo_reg.dy   <= dy_2_reg;
            geo_reg.d2   <= d2_next;
            geo_reg.diff <= diff_next;
            geo_reg.ok   <= ok_next;
            sq_reg       <= ok_next ? {diff_next, {(2*FRAC){1'b0}}} : '0;
        end
    end

    assign out_valid = v3_reg;
    assign geo       = geo_reg;
    assign sq_in     = sq_reg;

endmodule

// ----- src/citp_sqrt.sv -----
// Pipelined restoring square root, one result bit per stage.
`timescale 1ns / 1ps
module citp_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  citp_pkg::geo_t             geo,
    input  logic [citp_pkg::SQW-1:0]   sq_in,
    output logic                       out_valid,
    output citp_pkg::geo_t             geo_out,
    output logic [citp_pkg::TW-1:0]    root
);
    import citp_pkg::*;

    logic           vld_reg [SQ_STAGES];
    sq_t            st_reg  [SQ_STAGES];
    logic [SQW-1:0] x_reg   [SQ_STAGES];
    geo_t           geo_reg [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_st
        sq_t            st_in;
        logic [SQW-1:0] x_in;
        geo_t           geo_in;
        logic           v_in;

        if (s == 0)
        begin : g_first
            assign st_in  = '0;
            assign x_in   = sq_in;
            assign geo_in = geo;
            assign v_in   = in_valid;
        end
        else
        begin : g_rest
            assign st_in  = st_reg[s-1];
            assign x_in   = x_reg[s-1];
            assign geo_in = geo_reg[s-1];
            assign v_in   = vld_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= v_in;
        end

        // stage s consumes the next two radicand bits from the top
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[s]  <= sqrt_step(st_in, x_in[SQW-1-2*s -: 2]);
                x_reg[s]   <= x_in;
                geo_reg[s] <= geo_in;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign geo_out   = geo_reg[SQ_STAGES-1];
    assign root      = st_reg[SQ_STAGES-1].root;

endmodule

// ----- src/citp_terms.sv -----
// Coefficients, split products and signed numerators for the eight quotients.
`timescale 1ns / 1ps
module citp_terms (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  citp_pkg::geo_t                                geo,
    input  logic [citp_pkg::TW-1:0]                       root,
    output logic                                          out_valid,
    output logic [citp_pkg::LANES-1:0][citp_pkg::NW-1:0]  num,
    output logic [citp_pkg::DENW-1:0]                     den,
    output citp_pkg::dside_t                              side
);
    import citp_pkg::*;

    logic           v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [KW-1:0]  ksd_reg, ksq_reg, kdd_reg, kdq_reg;
    logic [VW-1:0]  adx_reg, ady_reg;
    tside_t         ts1_reg, ts2_reg, ts3_reg, ts4_reg;
    logic [KLW+VW-1:0] pplo_reg [PRODS];
    logic [KHW+VW-1:0] pphi_reg [PRODS];
    logic [PW-1:0]  prod_reg [PRODS];
    logic [LANES-1:0][NW-1:0] sum_reg;
    logic [LANES-1:0]         sneg_reg;
    logic [LANES-1:0][NW-1:0] num_reg;
    logic [DENW-1:0]          den_reg;
    dside_t         side_reg;

    logic [RW+TW-1:0]  ksq_full;
    logic [RRW+TW-1:0] kdq_full;
    logic [VW-1:0]     adx_next, ady_next;
    tside_t            ts1_next;
    logic [KW-1:0]     ksel [PRODS];
    logic [VW-1:0]     vsel [PRODS];
    logic [LANES-1:0][NW-1:0] sum_next;
    logic [LANES-1:0]         sneg_next;

    always_comb
    begin
        ksq_full     = geo.r1 * root;
        kdq_full     = geo.rr * root;
        adx_next     = geo.dx[DW-1] ? VW'(-geo.dx) : VW'(geo.dx);
        ady_next     = geo.dy[DW-1] ? VW'(-geo.dy) : VW'(geo.dy);
        ts1_next.x1  = geo.x1;
        ts1_next.y1  = geo.y1;
        ts1_next.dxn = geo.dx[DW-1];
        ts1_next.dyn = geo.dy[DW-1];
        // Q is D turned to point along +x (or +y on equal y); only its y sign varies
        ts1_next.qyn = (geo.dx != '0) && (geo.dy != '0) && (geo.dx[DW-1] == geo.dy[DW-1]);
        ts1_next.ok  = geo.ok;
        ts1_next.den = {geo.d2, {FRAC{1'b0}}};
    end

    always_comb
    begin
        ksel[P_SD_X] = ksd_reg;  vsel[P_SD_X] = adx_reg;
        ksel[P_SD_Y] = ksd_reg;  vsel[P_SD_Y] = ady_reg;
        ksel[P_SQ_Y] = ksq_reg;  vsel[P_SQ_Y] = ady_reg;
        ksel[P_SQ_X] = ksq_reg;  vsel[P_SQ_X] = adx_reg;
        ksel[P_DD_X] = kdd_reg;  vsel[P_DD_X] = adx_reg;
        ksel[P_DD_Y] = kdd_reg;  vsel[P_DD_Y] = ady_reg;
        ksel[P_DQ_Y] = kdq_reg;  vsel[P_DQ_Y] = ady_reg;
        ksel[P_DQ_X] = kdq_reg;  vsel[P_DQ_X] = adx_reg;
    end

    // signed sum of two products per lane
    always_comb
    begin
        logic [COMP_W-1:0] comp;
        logic              minus;
        logic [PIW-1:0]    ia, ib;
        logic              an, bn;
        logic [NW-1:0]     ma, mb;
        for (int l = 0; l < LANES; l++)
        begin
            comp  = COMP_W'(l % COMPS);
            minus = (l >= COMPS);
            unique case (comp)
                COMP_SX:
                begin
                    ia = P_SD_X; an = ts3_reg.dxn;
                    ib = P_SQ_Y; bn = minus;
                end
                COMP_SY:
                begin
                    ia = P_SD_Y; an = ts3_reg.dyn;
                    ib = P_SQ_X; bn = ts3_reg.qyn ^ minus;
                end
                COMP_VX:
                begin
                    ia = P_DD_X; an = ts3_reg.dxn;
                    ib = P_DQ_Y; bn = !minus;
                end
                COMP_VY:
                begin
                    ia = P_DD_Y; an = ts3_reg.dyn;
                    ib = P_DQ_X; bn = ts3_reg.qyn ^ !minus;
                end
                default:
                begin
                    ia = P_SD_X; an = 1'b0;
                    ib = P_SQ_Y; bn = 1'b0;
                end
            endcase
            ma = NW'(prod_reg[ia]);
            mb = NW'(prod_reg[ib]);
            if (an == bn)
            begin
                sum_next[l]  = ma + mb;
                sneg_next[l] = an;
            end
            else if (ma >= mb)
            begin
                sum_next[l]  = ma - mb;
                sneg_next[l] = an;
            end
            else
            begin
                sum_next[l]  = mb - ma;
                sneg_next[l] = bn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ksd_reg <= KW'({geo.r1rr, {FRAC{1'b0}}});
            ksq_reg <= KW'(ksq_full);
            kdd_reg <= KW'({geo.diff, {FRAC{1'b0}}});
            kdq_reg <= KW'(kdq_full);
            adx_reg <= adx_next;
            ady_reg <= ady_next;
            ts1_reg <= ts1_next;

            for (int p = 0; p < PRODS; p++)
            begin
                pplo_reg[p] <= (KLW+VW)'(ksel[p][KLW-1:0]) * (KLW+VW)'(vsel[p]);
                pphi_reg[p] <= (KHW+VW)'(ksel[p][KW-1:KLW]) * (KHW+VW)'(vsel[p]);
                prod_reg[p] <= (PW'(pphi_reg[p]) << KLW) + PW'(pplo_reg[p]);
            end
            ts2_reg <= ts1_reg;
            ts3_reg <= ts2_reg;

            sum_reg  <= sum_next;
            sneg_reg <= sneg_next;
            ts4_reg  <= ts3_reg;

            // add half the divisor so the floor divide rounds half away from zero
            for (int l = 0; l < LANES; l++)
                num_reg[l] <= sum_reg[l] + NW'(ts4_reg.den >> 1);
            side_reg.x1  <= ts4_reg.x1;
            side_reg.y1  <= ts4_reg.y1;
            side_reg.neg <= sneg_reg;
            side_reg.ok  <= ts4_reg.ok;
            den_reg      <= ts4_reg.den;
        end
    end

    assign out_valid = v5_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

// ----- src/citp_div.sv -----
// Eight-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module citp_div (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  logic [citp_pkg::LANES-1:0][citp_pkg::NW-1:0]  num,
    input  logic [citp_pkg::DENW-1:0]                     den,
    input  citp_pkg::dside_t                              side,
    output logic                                          out_valid,
    output logic [citp_pkg::LANES-1:0][citp_pkg::QW-1:0]  quo,
    output citp_pkg::dside_t                              side_out
);
    import citp_pkg::*;

    logic                     vld_reg  [DIV_STAGES];
    logic [LANES-1:0][NW-1:0] rem_reg  [DIV_STAGES];
    logic [LANES-1:0][QW-1:0] q_reg    [DIV_STAGES];
    logic [DENW-1:0]          den_reg  [DIV_STAGES];
    dside_t                   side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_st
        logic [LANES-1:0][NW-1:0] rem_in, rem_next;
        logic [LANES-1:0][QW-1:0] q_in, q_next;
        logic [DENW-1:0]          den_in;
        dside_t                   side_in;
        logic                     v_in;
        logic [NW-1:0]            shifted;

        if (s == 0)
        begin : g_first
            assign rem_in  = num;
            assign q_in    = '0;
            assign den_in  = den;
            assign side_in = side;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
            assign v_in    = vld_reg[s-1];
        end

        always_comb
        begin
            shifted = NW'(den_in) << (QW - 1 - s);
            for (int l = 0; l < LANES; l++)
            begin
                q_next[l] = q_in[l];
                if (rem_in[l] >= shifted)
                begin
                    rem_next[l]          = rem_in[l] - shifted;
                    q_next[l][QW-1-s]    = 1'b1;
                end
                else
                begin
                    rem_next[l]          = rem_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo       = q_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

// ----- src/circle_internal_tangents.sv -----
// Top level: internal tangent lines of two circles, fully pipelined.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   x1, y1, r1, x2, y2, r2 (144 bits)       -
//   m_axis    out  line0 sx,sy,vx,vy, line1 sx,sy,vx,vy    solution_valid
//
// One request per cycle sustained while the output is not held; the stages run front,
// root, product/sum, divide and output, with a bit-per-stage root and divider.
// rst_n clears the valid bits only; data registers are not reset.
// A held output stalls every stage together; s_tready is low exactly then.
`timescale 1ns / 1ps
module circle_internal_tangents (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // x1, y1, r1, x2, y2, r2, zero pad
    input  logic [citp_pkg::IN_TW-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // line0 start_x, start_y, dir_x, dir_y, line1 start_x, start_y, dir_x, dir_y
    output logic [citp_pkg::OUT_TW-1:0]   m_tdata,
    // solution_valid
    output logic                          m_tuser
);
    import citp_pkg::*;

    logic                     adv;
    logic                     fr_valid, sq_valid, tm_valid, dv_valid;
    geo_t                     fr_geo, sq_geo;
    logic [SQW-1:0]           fr_sq;
    logic [TW-1:0]            sq_root;
    logic [LANES-1:0][NW-1:0] tm_num;
    logic [DENW-1:0]          tm_den;
    dside_t                   tm_side, dv_side;
    logic [LANES-1:0][QW-1:0] dv_quo;
    logic [OUT_TW-1:0]        data_next;

    logic                     m_tvalid_reg;
    logic [OUT_TW-1:0]        m_tdata_reg;
    logic                     m_tuser_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    citp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .x1        (s_tdata[23:0]),
        .y1        (s_tdata[47:24]),
        .r1        (s_tdata[70:48]),
        .x2        (s_tdata[94:71]),
        .y2        (s_tdata[118:95]),
        .r2        (s_tdata[141:119]),
        .out_valid (fr_valid),
        .geo       (fr_geo),
        .sq_in     (fr_sq)
    );

    citp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .geo       (fr_geo),
        .sq_in     (fr_sq),
        .out_valid (sq_valid),
        .geo_out   (sq_geo),
        .root      (sq_root)
    );

    citp_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .geo       (sq_geo),
        .root      (sq_root),
        .out_valid (tm_valid),
        .num       (tm_num),
        .den       (tm_den),
        .side      (tm_side)
    );

    citp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (tm_valid),
        .num       (tm_num),
        .den       (tm_den),
        .side      (tm_side),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    // apply sign, add the first center for start points, saturate; all zero without a solution
    always_comb
    begin
        logic [COMP_W-1:0]   comp;
        logic signed [SW-1:0] mag_s, val_s, base_s, sum_s;
        for (int l = 0; l < LANES; l++)
        begin
            comp  = COMP_W'(l % COMPS);
            mag_s = $signed({{(SW-QW){1'b0}}, dv_quo[l]});
            val_s = dv_side.neg[l] ? -mag_s : mag_s;
            unique case (comp)
                COMP_SX: base_s = {{(SW-CW){dv_side.x1[CW-1]}}, dv_side.x1};
                COMP_SY: base_s = {{(SW-CW){dv_side.y1[CW-1]}}, dv_side.y1};
                COMP_VX: base_s = '0;
                COMP_VY: base_s = '0;
                default: base_s = '0;
            endcase
            sum_s = val_s + base_s;
            if (!dv_side.ok)
                data_next[l*CW +: CW] = '0;
            else if (sum_s > $signed(SW'(OUT_MAX)))
                data_next[l*CW +: CW] = CW'(OUT_MAX);
            else if (sum_s < $signed(SW'(OUT_MIN)))
                data_next[l*CW +: CW] = CW'(OUT_MIN);
            else
                data_next[l*CW +: CW] = sum_s[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= data_next;
            m_tuser_reg <= dv_side.ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- src/citp_chk.sv -----
// Port-level checker for circle_internal_tangents, bound to the top level.
`timescale 1ns / 1ps
`include "circle_internal_tangents_assert.svh"
module citp_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [citp_pkg::OUT_TW-1:0]   m_tdata,
    input  logic                          m_tuser
);
    // a held result keeps its request
    `CIT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `CIT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // no geometry means all-zero lines
    `CIT_ASSERT_SAME(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0)
    // input side only stalls behind a held result
    `CIT_ASSERT_SAME(a_ready_free, !m_tvalid || m_tready, s_tready)
    `CIT_ASSERT_SAME(a_ready_stall, m_tvalid && !m_tready, !s_tready)
endmodule

bind circle_internal_tangents citp_chk u_citp_chk (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the internal circle tangent pipeline.
`timescale 1ns / 1ps
module tb;
    import citp_pkg::*;

    localparam int N_RANDOM  = 1250;
    localparam int WD_LIMIT  = 5000;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic signed [CW-1:0] x1, y1, x2, y2;
        logic [RW-1:0]        r1, r2;
    } circle_pair_t;

    typedef struct {
        logic [OUT_TW-1:0] lines;
        logic              ok;
    } tangent_pair_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TW-1:0] m_tdata;
    logic m_tuser;

    circle_pair_t  pending_pairs[$];
    tangent_pair_t expected_tangents[$];
    int n_sent, n_got, n_valid_got, n_errors, idle_cycles;
    int burst_left, gap_left, stall_left, cyc;
    logic drain_pause, drain_done;

    circle_internal_tangents u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // round to nearest, ties away from zero, magnitude clamped to 2^30
    function automatic longint round_div(logic signed [127:0] n, logic signed [127:0] den);
        logic signed [127:0] mag, q;
        mag = (n < 0) ? -n : n;
        q   = (mag + (den >>> 1)) / den;
        if (q > (128'sd1 <<< 30))
            q = 128'sd1 <<< 30;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [CW-1:0] clip24(longint v);
        if (v > OUT_MAX)
            return CW'(OUT_MAX);
        if (v < OUT_MIN)
            return CW'(OUT_MIN);
        return CW'(v);
    endfunction

    function automatic tangent_pair_t solve_tangents(circle_pair_t c);
        tangent_pair_t res;
        longint x1, y1, dx, dy, qx, qy, d2, rr, rrsq, sgn;
        logic [63:0] t;
        logic signed [127:0] den, ksd, ksq, kdd, kdq;
        x1 = c.x1;
        y1 = c.y1;
        dx = longint'(c.x2) - x1;
        dy = longint'(c.y2) - y1;
        d2 = dx * dx + dy * dy;
        rr = longint'(c.r1) + longint'(c.r2);
        rrsq = rr * rr;
        res.lines = '0;
        res.ok    = 1'b0;
        if (d2 == 0 || d2 < rrsq)
            return res;
        t = root_floor(64'(d2 - rrsq) << (2 * FRAC));
        if (dy > 0)
        begin
            qx = dy;
            qy = -dx;
        end
        else if (dy < 0)
        begin
            qx = -dy;
            qy = dx;
        end
        else
        begin
            qx = 0;
            qy = (dx < 0) ? -dx : dx;
        end
        den = 128'(d2) <<< FRAC;
        ksd = (128'(c.r1) * 128'(rr)) <<< FRAC;
        ksq = 128'(c.r1) * $signed({64'd0, t});
        kdd = 128'(d2 - rrsq) <<< FRAC;
        kdq = 128'(rr) * $signed({64'd0, t});
        for (int ln = 0; ln < 2; ln++)
        begin
            sgn = (ln == 0) ? 1 : -1;
            res.lines[(4*ln+0)*CW +: CW] = clip24(x1 + round_div(ksd*dx + sgn*ksq*qx, den));
            res.lines[(4*ln+1)*CW +: CW] = clip24(y1 + round_div(ksd*dy + sgn*ksq*qy, den));
            res.lines[(4*ln+2)*CW +: CW] = clip24(round_div(kdd*dx - sgn*kdq*qx, den));
            res.lines[(4*ln+3)*CW +: CW] = clip24(round_div(kdd*dy - sgn*kdq*qy, den));
        end
        res.ok = 1'b1;
        return res;
    endfunction

    task automatic queue_pair(longint x1, longint y1, longint r1,
                              longint x2, longint y2, longint r2);
        circle_pair_t c;
        c.x1 = CW'(x1);
        c.y1 = CW'(y1);
        c.r1 = RW'(r1);
        c.x2 = CW'(x2);
        c.y2 = CW'(y2);
        c.r2 = RW'(r2);
        pending_pairs.push_back(c);
    endtask

    function automatic longint span_rand(int k);
        longint m;
        m = longint'(1) << k;
        return longint'($urandom_range(0, 32'(2 * m - 1))) - m;
    endfunction

    // sender: bursts and gaps, one pause that lets the pipeline drain
    always @(posedge clk)
    begin
        logic nv;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            nv = 1'b0;
            if (s_tvalid && s_tready)
            begin
                expected_tangents.push_back(solve_tangents(pending_pairs[0]));
                void'(pending_pairs.pop_front());
                n_sent++;
            end
            if (s_tvalid && !s_tready)
                nv = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (drain_pause && !drain_done)
            begin
                if (expected_tangents.size() == 0)
                    drain_done <= 1'b1;
            end
            else if (pending_pairs.size() > 0)
            begin
                nv = 1'b1;
                s_tdata <= {2'b00, pending_pairs[0].r2, pending_pairs[0].y2,
                            pending_pairs[0].x2, pending_pairs[0].r1,
                            pending_pairs[0].y1, pending_pairs[0].x1};
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (n_sent == 700)
                drain_pause <= 1'b1;
            s_tvalid <= nv;
        end
    end

    // receiver: stall behavior rotates through no stalls, frequent short stalls and rare long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            cyc++;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                case ((cyc >> 8) % 3)
                    1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
                    2: if ($urandom_range(0, 30) == 0) stall_left = $urandom_range(5, 25);
                    default: ;
                endcase
            end
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        tangent_pair_t e;
        logic bad;
        if (rst_n)
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
                idle_cycles = 0;
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                n_got++;
                if (expected_tangents.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("unexpected result %h valid %b", m_tdata, m_tuser);
                end
                else
                begin
                    e = expected_tangents.pop_front();
                    bad = (m_tuser !== e.ok);
                    for (int f = 0; f < LANES; f++)
                        if (m_tdata[f*CW +: CW] !== e.lines[f*CW +: CW])
                            bad = 1'b1;
                    if (e.ok)
                        n_valid_got++;
                    if (bad)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                        begin
                            $display("mismatch on result %0d: valid exp %b got %b",
                                     n_got, e.ok, m_tuser);
                            for (int f = 0; f < LANES; f++)
                                $display("  field %0d exp %h got %h", f,
                                         e.lines[f*CW +: CW], m_tdata[f*CW +: CW]);
                        end
                    end
                end
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", WD_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        longint x1, y1, x2, y2, lim, r1;
        int total, k;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        n_sent = 0; n_got = 0; n_valid_got = 0; n_errors = 0; idle_cycles = 0;
        burst_left = 0; gap_left = 0; stall_left = 0; cyc = 0;
        drain_pause = 1'b0; drain_done = 1'b0;

        // directed corners
        queue_pair(100, 200, 5, 100, 200, 5);                 // same center
        queue_pair(0, 0, 1000, 1500, 0, 1000);                // overlap
        queue_pair(0, 0, 300, 1000, 0, 700);                  // touching on equal y
        queue_pair(0, 0, 300, 600, 800, 700);                 // touching, slanted
        queue_pair(-50, 70, 0, 900, -300, 0);                 // both radii zero
        queue_pair(0, 0, 100, 2000, 0, 200);                  // equal y, dx > 0
        queue_pair(0, 0, 100, -2000, 0, 200);                 // equal y, dx < 0
        queue_pair(10, 10, 150, 500, 3000, 250);              // dy > 0
        queue_pair(10, 10, 150, 500, -3000, 250);             // dy < 0
        queue_pair(0, 0, 100, 0, 4000, 100);                  // vertical
        queue_pair(-8388608, -8388608, 0, 8388607, 8388607, 0);
        queue_pair(8388607, -8388608, 8388607, -8388608, 8388607, 8388607);
        queue_pair(-8388608, 0, 2000000, 8388607, 0, 2000000);
        queue_pair(-8388608, -8388608, 4000000, 8388607, 8388607, 4000000);
        queue_pair(8388607, 8388607, 8388607, 8388607, -8388608, 0);
        queue_pair(0, 0, 8388607, 1, 0, 8388607);
        queue_pair(-8388608, 8388607, 1, -8388608, 8388600, 2);
        queue_pair(0, 0, 1, 3, 0, 1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            k = $urandom_range(4, 23);
            x1 = span_rand(k);
            y1 = span_rand(k);
            x2 = span_rand(k);
            y2 = span_rand(k);
            case ($urandom_range(0, 9))
                0, 1: queue_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                7:
                begin
                    lim = ((x2 > x1) ? x2 - x1 : x1 - x2) / 3;
                    r1 = $urandom_range(0, 32'(lim));
                    queue_pair(x1, y1, r1, x2, y1, $urandom_range(0, 32'(lim - r1)));
                end
                8:
                begin
                    lim = ((y2 > y1) ? y2 - y1 : y1 - y2) / 3;
                    r1 = $urandom_range(0, 32'(lim));
                    queue_pair(x1, y1, r1, x1, y2, $urandom_range(0, 32'(lim - r1)));
                end
                9:
                begin
                    // touching circles on a common y, or a zero second radius when the gap was clipped
                    lim = (x2 > x1) ? x2 - x1 : x1 - x2;
                    if (lim > 8388607)
                        lim = 8388607;
                    r1 = $urandom_range(0, 32'(lim));
                    queue_pair(x1, y1, r1, x2, y1, lim == ((x2 > x1) ? x2 - x1 : x1 - x2)
                               ? lim - r1 : 0);
                end
                default:
                begin
                    lim = (((x2 > x1) ? x2 - x1 : x1 - x2) + ((y2 > y1) ? y2 - y1 : y1 - y2)) / 3;
                    if (lim > 8388607)
                        lim = 8388607;
                    r1 = $urandom_range(0, 32'(lim));
                    queue_pair(x1, y1, r1, x2, y2, $urandom_range(0, 32'(lim - r1)));
                end
            endcase
        end
        total = pending_pairs.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < total || expected_tangents.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d circle pairs sent, %0d results checked (%0d with tangents, %0d rejected)",
                 n_sent, n_got, n_valid_got, n_got - n_valid_got);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0 && expected_tangents.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- circle_internal_tangents.f -----
+incdir+src
src/citp_pkg.sv
src/citp_front.sv
src/citp_sqrt.sv
src/citp_terms.sv
src/citp_div.sv
src/circle_internal_tangents.sv
src/citp_chk.sv
tb/tb.sv
